>>> hw/rtl/aos_pkg.sv
// Shared types for the box overlap and separation block.
package aos_pkg;

    // Coordinate width in signed Q16.16.
    localparam int unsigned COORD_W = 32;

    // Per-axis result handed from the distance stage to the selection stage.
    typedef struct packed {
        logic [COORD_W-1:0] mag;      // smaller of the two distances, unsigned
        logic               pos;      // first distance strictly smaller
        logic               overlap;  // strict overlap on this axis
    } t_axis;

endpackage

>>> hw/rtl/aos_axis.sv
// Per-axis distances, smallest magnitude, direction and overlap test.
module aos_axis (
    input  logic signed [aos_pkg::COORD_W-1:0] i_a_min,
    input  logic signed [aos_pkg::COORD_W-1:0] i_a_max,
    input  logic signed [aos_pkg::COORD_W-1:0] i_b_min,
    input  logic signed [aos_pkg::COORD_W-1:0] i_b_max,
    output aos_pkg::t_axis                     o_axis
);

    localparam int unsigned W  = aos_pkg::COORD_W;
    localparam int unsigned DW = W + 2;

    logic signed [DW-1:0] diff0;
    logic signed [DW-1:0] diff1;
    logic signed [DW-1:0] neg0;
    logic signed [DW-1:0] neg1;
    logic        [W-1:0]  dist0;
    logic        [W-1:0]  dist1;
    logic                 lt;

    // Differences are exact at this width, and their magnitude fits in W bits.
    assign diff0 = {{2{i_a_max[W-1]}}, i_a_max} - {{2{i_b_min[W-1]}}, i_b_min};
    assign diff1 = {{2{i_b_max[W-1]}}, i_b_max} - {{2{i_a_min[W-1]}}, i_a_min};
    assign neg0  = -diff0;
    assign neg1  = -diff1;
    assign dist0 = diff0[DW-1] ? neg0[W-1:0] : diff0[W-1:0];
    assign dist1 = diff1[DW-1] ? neg1[W-1:0] : diff1[W-1:0];
    assign lt    = dist0 < dist1;

    always_comb begin
        o_axis.mag     = lt ? dist0 : dist1;
        o_axis.pos     = lt;
        o_axis.overlap = (i_a_max > i_b_min) && (i_a_min < i_b_max);
    end

endmodule

>>> hw/rtl/aos_select.sv
// Smallest-axis selection, sign application and saturation of the vector.
module aos_select (
    input  aos_pkg::t_axis                     i_ax,
    input  aos_pkg::t_axis                     i_ay,
    input  aos_pkg::t_axis                     i_az,
    output logic                               o_overlap,
    output logic signed [aos_pkg::COORD_W-1:0] o_sep_x,
    output logic signed [aos_pkg::COORD_W-1:0] o_sep_y,
    output logic signed [aos_pkg::COORD_W-1:0] o_sep_z
);

    localparam int unsigned W = aos_pkg::COORD_W;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

    logic keep_x;
    logic keep_y;
    logic keep_z;

    // Signed, saturated component from an unsigned magnitude.
    function automatic logic [W-1:0] f_signed_sat(input logic [W-1:0] mag, input logic pos);
        logic [W-1:0] res;
        if (pos) begin
            res = (mag > MAX_POS) ? MAX_POS : mag;
        end else begin
            res = (mag > MIN_NEG) ? MIN_NEG : (~mag + 1'b1);
        end
        return res;
    endfunction

    always_comb begin
        keep_x = 1'b1;
        keep_y = 1'b1;
        keep_z = 1'b1;
        // A strictly smallest axis zeroes the other two; a tie keeps all three.
        if ((i_ax.mag < i_ay.mag) && (i_ax.mag < i_az.mag)) begin
            keep_y = 1'b0;
            keep_z = 1'b0;
        end else if ((i_ay.mag < i_ax.mag) && (i_ay.mag < i_az.mag)) begin
            keep_x = 1'b0;
            keep_z = 1'b0;
        end else if ((i_az.mag < i_ax.mag) && (i_az.mag < i_ay.mag)) begin
            keep_x = 1'b0;
            keep_y = 1'b0;
        end

        o_overlap = i_ax.overlap & i_ay.overlap & i_az.overlap;
        o_sep_x   = keep_x ? f_signed_sat(i_ax.mag, i_ax.pos) : '0;
        o_sep_y   = keep_y ? f_signed_sat(i_ay.mag, i_ay.pos) : '0;
        o_sep_z   = keep_z ? f_signed_sat(i_az.mag, i_az.pos) : '0;
    end

endmodule

>>> hw/rtl/aabb_overlap_and_separation.sv
// Box overlap test and minimum separating vector, top level.
// o_valid rises once a transaction has passed the input register and then the result register.
// Throughput: one box pair per cycle; both stages advance whenever the next stage frees up.
// Reset clears the stage valid flags only; payload registers are not reset.
// The block holds no state between transactions.
module aabb_overlap_and_separation (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [aos_pkg::COORD_W-1:0] i_a_min_x,
    input  logic signed [aos_pkg::COORD_W-1:0] i_a_min_y,
    input  logic signed [aos_pkg::COORD_W-1:0] i_a_min_z,
    input  logic signed [aos_pkg::COORD_W-1:0] i_a_max_x,
    input  logic signed [aos_pkg::COORD_W-1:0] i_a_max_y,
    input  logic signed [aos_pkg::COORD_W-1:0] i_a_max_z,
    input  logic signed [aos_pkg::COORD_W-1:0] i_b_min_x,
    input  logic signed [aos_pkg::COORD_W-1:0] i_b_min_y,
    input  logic signed [aos_pkg::COORD_W-1:0] i_b_min_z,
    input  logic signed [aos_pkg::COORD_W-1:0] i_b_max_x,
    input  logic signed [aos_pkg::COORD_W-1:0] i_b_max_y,
    input  logic signed [aos_pkg::COORD_W-1:0] i_b_max_z,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_overlap,
    output logic signed [aos_pkg::COORD_W-1:0] o_sep_x,
    output logic signed [aos_pkg::COORD_W-1:0] o_sep_y,
    output logic signed [aos_pkg::COORD_W-1:0] o_sep_z
);

    localparam int unsigned W = aos_pkg::COORD_W;

    logic                r_in_valid;
    logic signed [W-1:0] r_a_min [3];
    logic signed [W-1:0] r_a_max [3];
    logic signed [W-1:0] r_b_min [3];
    logic signed [W-1:0] r_b_max [3];

    logic                r_out_valid;
    logic                r_overlap;
    logic signed [W-1:0] r_sep_x;
    logic signed [W-1:0] r_sep_y;
    logic signed [W-1:0] r_sep_z;

    logic                in_take;
    logic                out_load;
    logic                n_in_valid;
    logic                n_out_valid;
    logic                n_overlap;
    logic signed [W-1:0] n_sep_x;
    logic signed [W-1:0] n_sep_y;
    logic signed [W-1:0] n_sep_z;

    aos_pkg::t_axis axis_x;
    aos_pkg::t_axis axis_y;
    aos_pkg::t_axis axis_z;

    // The result register loads whenever it is empty or being drained.
    assign out_load = ~r_out_valid | i_ready;
    assign o_ready  = ~r_in_valid | out_load;
    assign in_take  = i_valid & o_ready;

    always_comb begin
        n_in_valid  = in_take | (r_in_valid & ~out_load);
        n_out_valid = out_load ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_min[0] <= i_a_min_x;
            r_a_min[1] <= i_a_min_y;
            r_a_min[2] <= i_a_min_z;
            r_a_max[0] <= i_a_max_x;
            r_a_max[1] <= i_a_max_y;
            r_a_max[2] <= i_a_max_z;
            r_b_min[0] <= i_b_min_x;
            r_b_min[1] <= i_b_min_y;
            r_b_min[2] <= i_b_min_z;
            r_b_max[0] <= i_b_max_x;
            r_b_max[1] <= i_b_max_y;
            r_b_max[2] <= i_b_max_z;
        end
    end

    aos_axis u_axis_x (
        .i_a_min (r_a_min[0]),
        .i_a_max (r_a_max[0]),
        .i_b_min (r_b_min[0]),
        .i_b_max (r_b_max[0]),
        .o_axis  (axis_x)
    );

    aos_axis u_axis_y (
        .i_a_min (r_a_min[1]),
        .i_a_max (r_a_max[1]),
        .i_b_min (r_b_min[1]),
        .i_b_max (r_b_max[1]),
        .o_axis  (axis_y)
    );

    aos_axis u_axis_z (
        .i_a_min (r_a_min[2]),
        .i_a_max (r_a_max[2]),
        .i_b_min (r_b_min[2]),
        .i_b_max (r_b_max[2]),
        .o_axis  (axis_z)
    );

    aos_select u_select (
        .i_ax      (axis_x),
        .i_ay      (axis_y),
        .i_az      (axis_z),
        .o_overlap (n_overlap),
        .o_sep_x   (n_sep_x),
        .o_sep_y   (n_sep_y),
        .o_sep_z   (n_sep_z)
    );

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_overlap <= n_overlap;
            r_sep_x   <= n_sep_x;
            r_sep_y   <= n_sep_y;
            r_sep_z   <= n_sep_z;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_overlap = r_overlap;
    assign o_sep_x   = r_sep_x;
    assign o_sep_y   = r_sep_y;
    assign o_sep_z   = r_sep_z;

endmodule
